@@ hw/rtl/pmtp_pkg.sv @@
// Shared codes and constants for the prescaled match timer pair.
package pmtp_pkg;

    // Beat kinds on the input channel
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    // Register selects for bus accesses
    typedef enum logic [1:0] {
        SEL_FLAGS = 2'd0,
        SEL_CTRL  = 2'd1,
        SEL_COUNT = 2'd2
    } sel_t;

    // Units that own configuration registers
    localparam int CFG_UNITS = 2;
    // Units reachable through the one-bit unit field
    localparam int ADDR_UNITS = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH0    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH1    = 3'd5;

endpackage

@@ hw/rtl/prescaled_match_timer_pair_unit.sv @@
// Top level: prescaled match timer units with bus access and match flags.
//
// Each input beat is either a clock tick, a bus write or a bus read. A tick
// advances every enabled unit's prescaler; when the prescaler has reached its
// prescale value it restarts and the 32-bit counter steps, comparing against
// the period for the flag and the optional restart. Exactly one result beat
// comes back per input beat, in order, in the cycle after acceptance; a new
// beat can be taken in every cycle unless s_ready is low, which is only while
// the single result register holds a result with m_ready low. read_data is
// zero for anything but a read; the irq outputs show the match flags as they
// stand after the beat. The user writes configuration (prescale, period, match
// control for units 0 and 1) through cfg_wr_en/cfg_index/cfg_wdata only while
// the block is idle (the block does not enforce it); units 2+ have no registers.
module prescaled_match_timer_pair_unit #(
    parameter int NUM_UNITS = 2
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic        s_unit,
    input  logic [1:0]  s_reg_select,
    input  logic [7:0]  s_write_data,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_irq_unit0,
    output logic        m_irq_unit1
);

    localparam int CW = pmtp_pkg::CNT_W;

    // configuration store
    logic [CW-1:0] prescale_reg   [pmtp_pkg::CFG_UNITS];
    logic [CW-1:0] period_reg     [pmtp_pkg::CFG_UNITS];
    logic [1:0]    match_ctrl_reg [pmtp_pkg::CFG_UNITS];

    // result register
    logic          m_valid_reg;
    logic [CW-1:0] read_data_reg;
    logic          irq0_reg;
    logic          irq1_reg;

    logic accept;
    logic is_tick;
    logic is_write;
    logic is_read;

    logic [NUM_UNITS-1:0] flag_next_vec;
    logic [CW-1:0]        unit_rdata [NUM_UNITS];
    logic [CW-1:0]        rdata_next;
    logic                 irq1_next;

    // ready whenever the result slot is empty or drains this cycle
    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_tick  = accept && (s_kind == pmtp_pkg::KIND_TICK);
    assign is_write = accept && (s_kind == pmtp_pkg::KIND_WRITE);
    assign is_read  = (s_kind == pmtp_pkg::KIND_READ);

    // configuration writes; unknown indexes fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < pmtp_pkg::CFG_UNITS; i++) begin
                prescale_reg[i]   <= '0;
                period_reg[i]     <= '0;
                match_ctrl_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pmtp_pkg::CFG_PRESCALE0: prescale_reg[0]   <= cfg_wdata;
                pmtp_pkg::CFG_PRESCALE1: prescale_reg[1]   <= cfg_wdata;
                pmtp_pkg::CFG_PERIOD0:   period_reg[0]     <= cfg_wdata;
                pmtp_pkg::CFG_PERIOD1:   period_reg[1]     <= cfg_wdata;
                pmtp_pkg::CFG_MATCH0:    match_ctrl_reg[0] <= cfg_wdata[1:0];
                pmtp_pkg::CFG_MATCH1:    match_ctrl_reg[1] <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // one timer slice per unit
    for (genvar u = 0; u < NUM_UNITS; u++) begin : g_unit
        logic [CW-1:0] pre;
        logic [CW-1:0] per;
        logic [1:0]    mc;
        logic          hit;

        logic [CW-1:0] pcount_reg, pcount_next;
        logic [CW-1:0] tcount_reg, tcount_next;
        logic          run_reg, run_next;
        logic          hold_reg, hold_next;
        logic          flag_reg, flag_next;
        logic [CW-1:0] tcount_adv;

        if (u < pmtp_pkg::CFG_UNITS) begin : g_cfg
            assign pre = prescale_reg[u];
            assign per = period_reg[u];
            assign mc  = match_ctrl_reg[u];
        end else begin : g_nocfg
            assign pre = '0;
            assign per = '0;
            assign mc  = '0;
        end

        if (u < pmtp_pkg::ADDR_UNITS) begin : g_addr
            assign hit = (s_unit == 1'(u));
        end else begin : g_noaddr
            assign hit = 1'b0;
        end

        // counter step, with restart when it sits on the period and match control bit 1 is set
        assign tcount_adv = (mc[1] && (tcount_reg == per)) ? '0 : tcount_reg + CW'(1);

        always_comb begin
            pcount_next = pcount_reg;
            tcount_next = tcount_reg;
            run_next    = run_reg;
            hold_next   = hold_reg;
            flag_next   = flag_reg;
            if (is_tick && run_reg && !hold_reg) begin
                if (pcount_reg < pre) begin
                    pcount_next = pcount_reg + CW'(1);
                end else begin
                    pcount_next = '0;
                    tcount_next = tcount_adv;
                    if (mc[0] && (tcount_adv == per)) begin
                        flag_next = 1'b1;
                    end
                end
            end
            if (is_write && hit) begin
                case (s_reg_select)
                    pmtp_pkg::SEL_FLAGS: begin
                        if (s_write_data[0]) begin
                            flag_next = 1'b0;
                        end
                    end
                    pmtp_pkg::SEL_CTRL: begin
                        run_next  = s_write_data[0];
                        hold_next = s_write_data[1];
                        if (s_write_data[1]) begin
                            pcount_next = '0;
                            tcount_next = '0;
                        end
                    end
                    default: ;
                endcase
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pcount_reg <= '0;
                tcount_reg <= '0;
                run_reg    <= 1'b0;
                hold_reg   <= 1'b0;
                flag_reg   <= 1'b0;
            end else begin
                pcount_reg <= pcount_next;
                tcount_reg <= tcount_next;
                run_reg    <= run_next;
                hold_reg   <= hold_next;
                flag_reg   <= flag_next;
            end
        end

        // read-back of the state before the beat
        always_comb begin
            unit_rdata[u] = '0;
            if (is_read && hit) begin
                case (s_reg_select)
                    pmtp_pkg::SEL_FLAGS: unit_rdata[u] = {{(CW-1){1'b0}}, flag_reg};
                    pmtp_pkg::SEL_CTRL:  unit_rdata[u] = {{(CW-2){1'b0}}, hold_reg, run_reg};
                    pmtp_pkg::SEL_COUNT: unit_rdata[u] = tcount_reg;
                    default:             unit_rdata[u] = '0;
                endcase
            end
        end

        assign flag_next_vec[u] = flag_next;
    end

    always_comb begin
        rdata_next = '0;
        for (int i = 0; i < NUM_UNITS; i++) begin
            rdata_next = rdata_next | unit_rdata[i];
        end
    end

    if (NUM_UNITS > 1) begin : g_irq1
        assign irq1_next = flag_next_vec[1];
    end else begin : g_noirq1
        assign irq1_next = 1'b0;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            read_data_reg <= rdata_next;
            irq0_reg      <= flag_next_vec[0];
            irq1_reg      <= irq1_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = read_data_reg;
    assign m_irq_unit0 = irq0_reg;
    assign m_irq_unit1 = irq1_reg;

endmodule

@@ hw/rtl/pmtp_checker.sv @@
// Port-level checks for the prescaled match timer pair, bound to the top level.
module pmtp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_kind,
    input logic        s_unit,
    input logic [1:0]  s_reg_select,
    input logic [7:0]  s_write_data,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_read_data,
    input logic        m_irq_unit0,
    input logic        m_irq_unit1
);

    logic beat_in;
    assign beat_in = aresetn && s_valid && s_ready;

    // ready only drops behind a waiting result
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with no result waiting");

    // every accepted beat gives a result in the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        beat_in |=> m_valid)
        else $error("no result after accepted beat");

    // anything but a read returns zero data
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat_in && (s_kind != pmtp_pkg::KIND_READ)) |=> (m_read_data == '0))
        else $error("non-zero read_data on non-read beat");

    // write-one-clear of unit 0 flag shows on the result of the clearing beat
    a_flag_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (beat_in && (s_kind == pmtp_pkg::KIND_WRITE) && !s_unit
         && (s_reg_select == pmtp_pkg::SEL_FLAGS) && s_write_data[0])
        |=> !m_irq_unit0)
        else $error("unit 0 flag not cleared");

    // a held result stays put
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_read_data)
                                   && $stable(m_irq_unit0) && $stable(m_irq_unit1)))
        else $error("stalled result changed");

endmodule

bind prescaled_match_timer_pair_unit pmtp_checker u_pmtp_checker (.*);
